### sv/wmf_pkg.sv
`default_nettype none

package wmf_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned VREF_W   = 13;
  localparam int unsigned MV_W     = 13;

  // Voltage scaling: (code * vref) >> SCALE_SHIFT
  localparam int unsigned SCALE_SHIFT = 12;
  localparam int unsigned PROD_W      = SAMPLE_W + VREF_W;

  // Defaults
  localparam int unsigned WINDOW_DEF = 4;
  localparam logic [VREF_W-1:0] VREF_RESET = 13'd3300;

  // Link between neighbouring sort cells
  typedef struct packed {
    logic                valid;  // cell holds a sample of the current group
    logic                gt;     // held sample is greater than the incoming one
    logic [SAMPLE_W-1:0] val;    // held sample
  } link_t;

endpackage

`default_nettype wire

### sv/wmf_cell.sv
`default_nettype none

// One cell of the insertion-sort chain. Cells hold the current group in
// ascending order; on an insert each cell keeps, shifts up from its left
// neighbour, or takes the new sample.
module wmf_cell (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               load,
  input  wire                               restart,
  input  wire  [wmf_pkg::SAMPLE_W-1:0]      din,
  input  wmf_pkg::link_t                    left,
  output wmf_pkg::link_t                    right
);

  logic                         valid;
  logic [wmf_pkg::SAMPLE_W-1:0] val;
  logic                         valid_eff;
  logic                         gt;

  // A finished group is discarded as the next one starts
  assign valid_eff = valid & ~restart;
  assign gt        = valid_eff & (val > din);

  assign right.valid = valid_eff;
  assign right.gt    = gt;
  assign right.val   = val;

  // Occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_eff | left.valid;
    end else if (restart) begin
      valid <= 1'b0;
    end
  end

  // Held sample
  always_ff @(posedge clk) begin
    if (load) begin
      if (valid_eff && !gt) begin
        val <= val;
      end else if (left.gt) begin
        val <= left.val;
      end else if (left.valid) begin
        val <= din;
      end
    end
  end

endmodule

`default_nettype wire

### sv/wmf_scale.sv
`default_nettype none

// Median of the two middle cells, then scaling to millivolts.
module wmf_scale (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               group_done,
  input  wire  [wmf_pkg::SAMPLE_W-1:0]      lo,
  input  wire  [wmf_pkg::SAMPLE_W-1:0]      hi,
  input  wire  [wmf_pkg::VREF_W-1:0]        vref_mv,
  output logic                              done,
  output logic [wmf_pkg::SAMPLE_W-1:0]      median_code,
  output logic [wmf_pkg::MV_W-1:0]          millivolts
);

  logic                         med_vld;
  logic [wmf_pkg::SAMPLE_W-1:0] med;
  logic [wmf_pkg::SAMPLE_W:0]   sum;
  logic [wmf_pkg::PROD_W-1:0]   prod;

  assign sum  = {1'b0, lo} + {1'b0, hi};
  assign prod = {{wmf_pkg::VREF_W{1'b0}}, med} * {{wmf_pkg::SAMPLE_W{1'b0}}, vref_mv};

  // Strobes
  always_ff @(posedge clk) begin
    if (rst) begin
      med_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      med_vld <= group_done;
      done    <= med_vld;
    end
  end

  // Median stage: truncating mean of the middle pair
  always_ff @(posedge clk) begin
    if (group_done) begin
      med <= sum[wmf_pkg::SAMPLE_W:1];
    end
  end

  // Scaling stage
  always_ff @(posedge clk) begin
    if (med_vld) begin
      median_code <= med;
      millivolts  <= prod[wmf_pkg::SCALE_SHIFT +: wmf_pkg::MV_W];
    end
  end

endmodule

`default_nettype wire

### sv/windowed_median_adc_filter.sv
`default_nettype none

// Windowed median filter for 12-bit ADC samples.
// Input: a sample is taken at each rising edge with start high and busy low.
// busy stays low, so one sample can be taken in every cycle.
// Samples are gathered in groups of WINDOW; each one is inserted into a
// chain of WINDOW sort cells in the cycle it is taken. When a group is
// complete the two middle cells are averaged (truncated) and the result is
// scaled: millivolts = (median * vref_mv) >> 12.
// Output: done is high for exactly one cycle carrying median_code and
// millivolts; the receiver cannot stall and must take it in that cycle.
// Result path: the last sample of a group enters the cell chain as
// group_done is registered; the median register and output register follow.
// Configuration: vref_mv is written when cfg_valid is high (cfg_ready is
// always high); write it only while no group result is in flight.
// Reset (rst, synchronous): the current group is discarded, vref_mv returns
// to 3300 mV and no result is pending.
module windowed_median_adc_filter #(
  parameter int unsigned WINDOW = wmf_pkg::WINDOW_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               start,
  output logic                              busy,
  input  wire  [wmf_pkg::SAMPLE_W-1:0]      sample,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [wmf_pkg::VREF_W-1:0]        cfg_data,
  output logic                              done,
  output logic [wmf_pkg::SAMPLE_W-1:0]      median_code,
  output logic [wmf_pkg::MV_W-1:0]          millivolts
);

  localparam int unsigned LO_POS = (WINDOW - 1) / 2;
  localparam int unsigned HI_POS = WINDOW / 2;

  logic                         accept;
  logic                         group_done;
  logic [wmf_pkg::VREF_W-1:0]   vref_mv;
  wmf_pkg::link_t               links [WINDOW+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Reference voltage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vref_mv <= wmf_pkg::VREF_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vref_mv <= cfg_data;
    end
  end

  // Head of the chain: always open, never greater
  assign links[0].valid = 1'b1;
  assign links[0].gt    = 1'b0;
  assign links[0].val   = '0;

  // Sort cell chain
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    wmf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .load    (accept),
      .restart (group_done),
      .din     (sample),
      .left    (links[i]),
      .right   (links[i+1])
    );
  end

  // Group complete once the last cell fills
  always_ff @(posedge clk) begin
    if (rst) begin
      group_done <= 1'b0;
    end else begin
      group_done <= accept & links[WINDOW-1].valid;
    end
  end

  wmf_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .group_done  (group_done),
    .lo          (links[LO_POS+1].val),
    .hi          (links[HI_POS+1].val),
    .vref_mv     (vref_mv),
    .done        (done),
    .median_code (median_code),
    .millivolts  (millivolts)
  );

`ifndef NO_ASSERTIONS
  // A group needs at least two samples, so completions never run back to back
  a_group_spacing: assert property (@(posedge clk) disable iff (rst)
    group_done |=> !group_done)
    else $error("group completion on consecutive cycles");

  // Every result comes from an earlier completed group
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(group_done, 2))
    else $error("result without a completed group");

  // After any insert the lowest cell is occupied
  a_head_filled: assert property (@(posedge clk) disable iff (rst)
    accept |=> (links[1].valid || group_done))
    else $error("insert left the first cell empty");
`endif

endmodule

`default_nettype wire

### bench/windowed_median_adc_filter_tb.sv
`default_nettype none

module windowed_median_adc_filter_tb;
  import wmf_pkg::*;

  localparam int WIN     = WINDOW_DEF;
  localparam int PERIOD  = 12;
  localparam int SETTLE  = 6;   // idle edges once no median is outstanding
  localparam int PHASE_N = 110;

  // One group median as it should leave the block
  typedef struct {
    logic [SAMPLE_W-1:0] code;
    logic [MV_W-1:0]     mv;
  } median_result_t;

  // Scoreboard: shadows vref_mv and the open group, queues the medians due
  class median_scoreboard;
    logic [VREF_W-1:0]   vref;
    logic [SAMPLE_W-1:0] group_q[$];
    median_result_t      pending_q[$];
    int                  errors;

    function new();
      vref   = VREF_RESET;
      errors = 0;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    // Accepted sample transaction; a full group yields one median
    function void note_sample(logic [SAMPLE_W-1:0] s);
      logic [SAMPLE_W-1:0] srt [WIN];
      logic [SAMPLE_W-1:0] key;
      logic [SAMPLE_W:0]   pair_sum;
      logic [PROD_W-1:0]   prod;
      median_result_t      res;
      int                  j;
      group_q.push_back(s);
      if (group_q.size() < WIN) return;
      foreach (srt[i]) srt[i] = group_q[i];
      group_q.delete();
      // insertion sort, ascending
      for (int i = 1; i < WIN; i++) begin
        key = srt[i];
        j   = i;
        while (j > 0 && srt[j-1] > key) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = key;
      end
      pair_sum = srt[(WIN-1)/2] + srt[WIN/2];
      res.code = pair_sum[SAMPLE_W:1];
      prod     = res.code * vref;
      res.mv   = prod[PROD_W-1:SCALE_SHIFT];
      pending_q.push_back(res);
    endfunction

    task check_median(logic [SAMPLE_W-1:0] code, logic [MV_W-1:0] mv);
      median_result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("median %0d / %0d mV with none outstanding", code, mv));
        return;
      end
      want = pending_q.pop_front();
      if (code !== want.code)
        report($sformatf("median_code %0d, want %0d", code, want.code));
      if (mv !== want.mv)
        report($sformatf("millivolts %0d, want %0d (code %0d, vref %0d)",
                         mv, want.mv, want.code, vref));
    endtask

    task close();
      while (pending_q.size() != 0) begin
        report($sformatf("median %0d never seen", pending_q[0].code));
        void'(pending_q.pop_front());
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic                cfg_valid = 1'b0;
  logic [VREF_W-1:0]   cfg_data = '0;
  logic                busy;
  logic                cfg_ready;
  logic                done;
  logic [SAMPLE_W-1:0] median_code;
  logic [MV_W-1:0]     millivolts;

  median_scoreboard    sb;
  bit                  idle_en = 1'b1;
  logic [SAMPLE_W-1:0] last_sample = '0;

  windowed_median_adc_filter u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample      (sample),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .done        (done),
    .median_code (median_code),
    .millivolts  (millivolts)
  );

  always #(PERIOD/2) clk = ~clk;

  // Monitor: transactions as seen at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.vref = cfg_data;
      if (start && !busy) sb.note_sample(sample);
      if (done) sb.check_median(median_code, millivolts);
    end
  end

  // Present one sample after a random gap; returns at the accepting edge
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    while (idle_en && $urandom_range(99) < 21) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    sample <= s;
    last_sample = s;
    do @(posedge clk); while (busy);
  endtask

  // Stop sending until every due median has come out, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_vref(input logic [VREF_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random sample: extremes, near neighbours (ties, close values), full range
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(9))
      0:       v = 0;
      1:       v = 4095;
      2, 3, 4: v = int'(last_sample) + int'($urandom_range(32)) - 16;
      5:       v = $urandom_range(15);
      6:       v = $urandom_range(4095, 4080);
      default: v = $urandom_range(4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // Directed groups: all low, all high, split extremes, odd middle sum,
  // descending order, alternating pair, duplicated middle values
  logic [SAMPLE_W-1:0] directed [28] = '{
    12'd0,    12'd0,    12'd0,    12'd0,
    12'd4095, 12'd4095, 12'd4095, 12'd4095,
    12'd0,    12'd4095, 12'd4095, 12'd0,
    12'd1,    12'd2,    12'd3,    12'd4,
    12'd4095, 12'd4094, 12'd1,    12'd0,
    12'd2048, 12'd2047, 12'd2048, 12'd2047,
    12'd3000, 12'd100,  12'd7,    12'd100
  };

  logic [VREF_W-1:0] vref_plan [8];

  initial begin
    sb = new();
    vref_plan = '{13'd0, 13'd8191, 13'd5000, 13'd1, 13'd4096,
                  13'(($urandom_range(5000))),
                  13'(($urandom_range(8191, 5001))), 13'd3300};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset reference
    foreach (directed[i]) send_sample(directed[i]);

    // random phases, one reference setting each
    foreach (vref_plan[p]) begin
      drain();
      write_vref(vref_plan[p]);
      idle_en = (p != 3);
      repeat (PHASE_N) send_sample(pick_sample());
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    sb.close();
    if (sb.errors == 0)
      $display("windowed_median_adc_filter test passed");
    else
      $display("windowed_median_adc_filter test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #(PERIOD * 400000);
    $display("windowed_median_adc_filter test failed");
    $finish;
  end

endmodule

`default_nettype wire
